### hw/rtl/mrrq_pkg.sv
// mrrq_pkg: shared operation codes, status codes and constants of the retransmit queue core.
// No dependencies.
`timescale 1ns / 1ps
package mrrq_pkg;
  localparam logic [1:0] OP_ENQ    = 2'd0;
  localparam logic [1:0] OP_SEND   = 2'd1;
  localparam logic [1:0] OP_ACK    = 2'd2;
  localparam logic [1:0] OP_REWIND = 2'd3;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NOTHING  = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_REFUSED  = 2'd3;

  localparam logic [31:0] BUDGET_RESET = 32'd1048576;
endpackage

### hw/rtl/mrrq_ram.sv
// mrrq_ram: generic single write port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module mrrq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### hw/rtl/multi_run_retransmit_queue_core.sv
// multi_run_retransmit_queue_core: top level of the retransmit queue.
// Depends on mrrq_pkg and mrrq_ram.
`timescale 1ns / 1ps
// Retransmit store: commands sit in per-run FIFO queues until acknowledged.
// Slave channel s_axis_*: one request per item, tdata packs operation, run,
// seq, tag and bytes. Master channel m_axis_*: exactly one result per request.
// Config: byte_budget_we_i / byte_budget_i write the byte budget, idle only;
// the user keeps to that rule, as the block itself does not enforce it.
// One request is handled at a time. The sequencer walks per operation:
//   enqueue  free entry scan, run match, then free slot, tail read, tail
//            link write, entry write, out
//   send     min search, then per run tried a setup step and a next-larger
//            search that may restart as a min search; entry read, update,
//            out
//   ack      slot search, a read and a check per list entry walked, fix,
//            then a round-robin search if the drained run held the turn, out
//   rewind   pointer reset, minimum key search, out
// A shared compare unit on the scanned slot key does all run-key compares;
// entry payload lives in a RAM with a registered read port, so each link
// hop passes a read state and a check state. The next request can be taken in the cycle after the result leaves.
// Reset clears the valid bits, slots and counters at once; no clearing pass.
// When the receiver stalls the result waits in the output register and no
// new request is taken until it leaves.
module multi_run_retransmit_queue_core #(
  parameter int ENTRY_DEPTH = 64,
  parameter int RUN_SLOTS   = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // operation[1:0], run_number[33:2], seq_num[65:34], command_tag[97:66],
  // command_bytes[118:98], zero pad to 120
  input  logic [119:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], out_run[33:2], out_seq[65:34], out_tag[97:66],
  // queued_total[104:98], bytes_held[136:105], zero pad to 144
  output logic [143:0] m_axis_tdata,
  input  logic         byte_budget_we_i,
  input  logic [31:0]  byte_budget_i
);
  localparam int EW = $clog2(ENTRY_DEPTH);
  localparam int LW = $clog2(ENTRY_DEPTH + 1);
  localparam int SW = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
  localparam int SCW = $clog2(RUN_SLOTS + 1);
  localparam int CW = $clog2(ENTRY_DEPTH + 1);
  localparam logic [LW-1:0] NIL = LW'(ENTRY_DEPTH);
  localparam int RW = 32 + 32 + 21 + LW; // seq, tag, size, link

  typedef enum logic [4:0] {
    S_IDLE, S_ENQ_SCAN, S_ENQ_SLOT, S_ENQ_FREE, S_ENQ_TW, S_ENQ_LINK, S_ENQ_DO,
    S_SND_MIN, S_SND_TRY, S_SND_NX, S_SND_RD, S_SND_OUT,
    S_ACK_SLOT, S_ACK_RD, S_ACK_CHK, S_ACK_FIX, S_ACK_NX,
    S_RW_SET, S_RW_MIN, S_OUT
  } state_e;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] tag;
    logic [20:0] size;
    logic [LW-1:0] link;
  } entry_t;

  state_e state_q;
  logic [31:0] budget_q;
  logic [ENTRY_DEPTH-1:0] valid_q;
  logic [RUN_SLOTS-1:0] used_q;
  logic [31:0] key_q [RUN_SLOTS];
  logic [LW-1:0] head_q [RUN_SLOTS];
  logic [LW-1:0] tail_q [RUN_SLOTS];
  logic [LW-1:0] send_q [RUN_SLOTS];
  logic [SW-1:0] rr_q;
  logic [CW-1:0] cnt_q;
  logic [31:0] bytes_q;

  logic [31:0] run_q, seq_q, tag_q;
  logic [20:0] size_q;
  logic [143:0] out_q;
  logic out_v_q;

  logic [EW-1:0] ei_q;       // entry scan index / chosen entry
  logic [SW-1:0] si_q;       // slot scan index
  logic [SCW-1:0] sn_q;      // slot scan step count
  logic [SW-1:0] slot_q;     // chosen slot
  logic [SW-1:0] best_q;     // scan best
  logic best_v_q;
  logic fresh_q;
  logic [SW-1:0] start_q, cur_q;
  logic [LW-1:0] ecur_q, eprev_q;
  logic [SCW-1:0] tries_q;
  logic [CW-1:0] hops_q;
  logic [31:0] rkey_q;       // reference key for next-slot search
  logic nxmode_q;            // 0 min search, 1 next-larger search

  // RAM
  logic ram_we;
  logic [EW-1:0] ram_wa, ram_ra;
  entry_t ram_wd, ram_rd;
  mrrq_ram #(.Width(RW), .Depth(ENTRY_DEPTH)) u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_wa), .wdata_i(ram_wd),
    .raddr_i(ram_ra), .rdata_o(ram_rd)
  );

  // previous entry word kept for the unlink rewrite
  entry_t prev_q;

  // shared compare unit: key of scanned slot vs reference
  logic [31:0] sk;
  logic gt_ref, lt_best, eq_run;
  assign sk = key_q[si_q];
  assign gt_ref = sk > rkey_q;
  assign lt_best = !best_v_q || (sk < key_q[best_q]);
  assign eq_run = sk == run_q;

  // walked entry holds the acknowledged sequence number
  logic ack_hit;
  assign ack_hit = valid_q[ecur_q[EW-1:0]] && (ram_rd.seq == seq_q);

  assign s_axis_tready = (state_q == S_IDLE) && !out_v_q;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = out_q;

  logic last_slot;
  assign last_slot = (sn_q == SCW'(RUN_SLOTS - 1));

  // scan candidate for min / next-larger search
  logic cand;
  assign cand = used_q[si_q] && (!nxmode_q || gt_ref) && lt_best;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      budget_q <= mrrq_pkg::BUDGET_RESET;
      valid_q <= '0;
      used_q <= '0;
      for (int i = 0; i < RUN_SLOTS; i++) begin
        head_q[i] <= NIL; tail_q[i] <= NIL; send_q[i] <= NIL;
      end
      rr_q <= '0; cnt_q <= '0; bytes_q <= '0; out_v_q <= 1'b0;
    end else begin
      if (byte_budget_we_i) budget_q <= byte_budget_i;
      if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          run_q <= s_axis_tdata[33:2];
          seq_q <= s_axis_tdata[65:34];
          tag_q <= s_axis_tdata[97:66];
          size_q <= s_axis_tdata[118:98];
          ei_q <= '0; si_q <= '0; sn_q <= '0; best_v_q <= 1'b0; best_q <= '0;
          nxmode_q <= 1'b0; fresh_q <= 1'b0;
          unique case (s_axis_tdata[1:0])
            mrrq_pkg::OP_ENQ:  state_q <= S_ENQ_SCAN;
            mrrq_pkg::OP_SEND: state_q <= S_SND_MIN;
            mrrq_pkg::OP_ACK:  state_q <= S_ACK_SLOT;
            default:           state_q <= S_RW_SET;
          endcase
        end
        // ---- enqueue ----
        S_ENQ_SCAN: begin
          if (bytes_q > budget_q) begin
            out_q <= {7'd0, bytes_q, 7'(cnt_q), 96'd0, mrrq_pkg::ST_REFUSED};
            state_q <= S_OUT;
          end else if (!valid_q[ei_q]) begin
            state_q <= S_ENQ_SLOT;
          end else if (ei_q == EW'(ENTRY_DEPTH - 1)) begin
            out_q <= {7'd0, bytes_q, 7'(cnt_q), 96'd0, mrrq_pkg::ST_REFUSED};
            state_q <= S_OUT;
          end else ei_q <= ei_q + 1'b1;
        end
        S_ENQ_SLOT: begin
          if (used_q[si_q] && eq_run) begin
            slot_q <= si_q; state_q <= S_ENQ_LINK;
          end else if (last_slot) begin
            si_q <= '0; sn_q <= '0; state_q <= S_ENQ_FREE;
          end else begin
            si_q <= si_q + 1'b1; sn_q <= sn_q + 1'b1;
          end
        end
        S_ENQ_FREE: begin
          if (!used_q[si_q]) begin
            slot_q <= si_q; fresh_q <= 1'b1;
            if (used_q == '0) rr_q <= si_q;
            state_q <= S_ENQ_LINK;
          end else if (last_slot) begin
            out_q <= {7'd0, bytes_q, 7'(cnt_q), 96'd0, mrrq_pkg::ST_REFUSED};
            state_q <= S_OUT;
          end else begin
            si_q <= si_q + 1'b1; sn_q <= sn_q + 1'b1;
          end
        end
        S_ENQ_LINK: state_q <= S_ENQ_TW; // tail word read
        S_ENQ_TW: state_q <= S_ENQ_DO;   // tail link write
        S_ENQ_DO: begin
          valid_q[ei_q] <= 1'b1;
          if (fresh_q) begin
            used_q[slot_q] <= 1'b1; key_q[slot_q] <= run_q;
            head_q[slot_q] <= LW'(ei_q);
          end else if (tail_q[slot_q] == NIL) head_q[slot_q] <= LW'(ei_q);
          tail_q[slot_q] <= LW'(ei_q);
          if (send_q[slot_q] == NIL) send_q[slot_q] <= LW'(ei_q);
          cnt_q <= cnt_q + 1'b1;
          bytes_q <= bytes_q + 32'(size_q);
          out_q <= {7'd0, bytes_q + 32'(size_q), 7'(cnt_q + 1'b1), 96'd0,
                    mrrq_pkg::ST_DONE};
          state_q <= S_OUT;
        end
        // ---- send ----
        S_SND_MIN: begin // find min slot into best
          if (cand) begin best_q <= si_q; best_v_q <= 1'b1; end
          if (last_slot) begin
            if (!(best_v_q || cand)) begin
              out_q <= {7'd0, bytes_q, 7'(cnt_q), 96'd0, mrrq_pkg::ST_NOTHING};
              state_q <= S_OUT;
            end else begin
              if (used_q[rr_q]) begin start_q <= rr_q; cur_q <= rr_q; end
              else begin
                start_q <= cand ? si_q : best_q; cur_q <= cand ? si_q : best_q;
              end
              tries_q <= '0; state_q <= S_SND_TRY;
            end
          end else begin si_q <= si_q + 1'b1; sn_q <= sn_q + 1'b1; end
        end
        S_SND_TRY: begin
          rkey_q <= key_q[cur_q]; nxmode_q <= 1'b1;
          si_q <= '0; sn_q <= '0; best_v_q <= 1'b0; best_q <= '0;
          state_q <= S_SND_NX;
        end
        S_SND_NX: begin // next-larger, falling back to min
          if (cand) begin best_q <= si_q; best_v_q <= 1'b1; end
          if (last_slot) begin
            if (best_v_q || cand) begin
              slot_q <= cand ? si_q : best_q;
              if (send_q[cur_q] != NIL) state_q <= S_SND_RD;
              else begin
                tries_q <= tries_q + 1'b1;
                if ((cand ? si_q : best_q) == start_q ||
                    tries_q == SCW'(RUN_SLOTS - 1)) begin
                  out_q <= {7'd0, bytes_q, 7'(cnt_q), 96'd0,
                            mrrq_pkg::ST_NOTHING};
                  state_q <= S_OUT;
                end else begin
                  cur_q <= cand ? si_q : best_q; state_q <= S_SND_TRY;
                end
              end
            end else begin
              // none larger: restart as min search
              nxmode_q <= 1'b0; si_q <= '0; sn_q <= '0;
            end
          end else begin si_q <= si_q + 1'b1; sn_q <= sn_q + 1'b1; end
        end
        S_SND_RD: state_q <= S_SND_OUT;
        S_SND_OUT: begin
          send_q[cur_q] <= ram_rd.link;
          rr_q <= slot_q;
          out_q <= {7'd0, bytes_q, 7'(cnt_q), ram_rd.tag, ram_rd.seq, key_q[cur_q],
                    mrrq_pkg::ST_DONE};
          state_q <= S_OUT;
        end
        // ---- acknowledge ----
        S_ACK_SLOT: begin
          if (used_q[si_q] && eq_run) begin
            slot_q <= si_q; ecur_q <= head_q[si_q]; eprev_q <= NIL; hops_q <= '0;
            state_q <= S_ACK_RD;
          end else if (last_slot) begin
            out_q <= {7'd0, bytes_q, 7'(cnt_q), 96'd0, mrrq_pkg::ST_NOTFOUND};
            state_q <= S_OUT;
          end else begin si_q <= si_q + 1'b1; sn_q <= sn_q + 1'b1; end
        end
        S_ACK_RD: begin
          if (ecur_q == NIL || hops_q == CW'(ENTRY_DEPTH)) begin
            out_q <= {7'd0, bytes_q, 7'(cnt_q), 96'd0, mrrq_pkg::ST_NOTFOUND};
            state_q <= S_OUT;
          end else state_q <= S_ACK_CHK;
        end
        S_ACK_CHK: begin
          if (ack_hit) state_q <= S_ACK_FIX;
          else begin
            eprev_q <= ecur_q; ecur_q <= ram_rd.link; hops_q <= hops_q + 1'b1;
            state_q <= S_ACK_RD;
          end
        end
        S_ACK_FIX: begin // prev link rewrite via RAM port in this state
          valid_q[ecur_q[EW-1:0]] <= 1'b0;
          cnt_q <= cnt_q - 1'b1;
          bytes_q <= bytes_q - 32'(ram_rd.size);
          out_q <= {7'd0, bytes_q - 32'(ram_rd.size), 7'(cnt_q - 1'b1), ram_rd.tag,
                    seq_q, run_q, mrrq_pkg::ST_DONE};
          if (eprev_q == NIL && ram_rd.link == NIL) begin
            // run drained: free its slot
            used_q[slot_q] <= 1'b0;
            head_q[slot_q] <= NIL; tail_q[slot_q] <= NIL; send_q[slot_q] <= NIL;
            if (rr_q == slot_q) begin
              rkey_q <= key_q[slot_q]; nxmode_q <= 1'b1;
              si_q <= '0; sn_q <= '0; best_v_q <= 1'b0; best_q <= '0;
              state_q <= S_ACK_NX;
            end else state_q <= S_OUT;
          end else begin
            if (eprev_q == NIL) head_q[slot_q] <= ram_rd.link;
            if (tail_q[slot_q] == ecur_q) tail_q[slot_q] <= eprev_q;
            if (send_q[slot_q] == ecur_q) send_q[slot_q] <= ram_rd.link;
            state_q <= S_OUT;
          end
        end
        S_ACK_NX: begin // slot already cleared in used_q
          if (cand) begin best_q <= si_q; best_v_q <= 1'b1; end
          if (last_slot) begin
            if (best_v_q || cand) begin
              rr_q <= cand ? si_q : best_q; state_q <= S_OUT;
            end else if (nxmode_q) begin
              nxmode_q <= 1'b0; si_q <= '0; sn_q <= '0;
            end else begin rr_q <= '0; state_q <= S_OUT; end
          end else begin si_q <= si_q + 1'b1; sn_q <= sn_q + 1'b1; end
        end
        // ---- rewind ----
        S_RW_SET: begin
          for (int i = 0; i < RUN_SLOTS; i++)
            if (used_q[i]) send_q[i] <= head_q[i];
          state_q <= S_RW_MIN;
        end
        S_RW_MIN: begin
          if (cand) begin best_q <= si_q; best_v_q <= 1'b1; end
          if (last_slot) begin
            rr_q <= cand ? si_q : (best_v_q ? best_q : '0);
            out_q <= {7'd0, bytes_q, 7'(cnt_q), 96'd0, mrrq_pkg::ST_DONE};
            state_q <= S_OUT;
          end else begin si_q <= si_q + 1'b1; sn_q <= sn_q + 1'b1; end
        end
        S_OUT: begin
          out_v_q <= 1'b1; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // RAM port control
  always_comb begin
    ram_we = 1'b0;
    ram_wa = ei_q;
    ram_wd = '{seq: seq_q, tag: tag_q, size: size_q, link: NIL};
    ram_ra = ecur_q[EW-1:0];
    unique case (state_q)
      S_ENQ_TW: if (!fresh_q && tail_q[slot_q] != NIL) begin
        // tail word was read in S_ENQ_LINK; rewrite it with the new link
        ram_we = 1'b1;
        ram_wa = tail_q[slot_q][EW-1:0];
        ram_wd = ram_rd;
        ram_wd.link = LW'(ei_q);
      end
      S_ENQ_DO: ram_we = 1'b1;
      S_ACK_FIX: if (eprev_q != NIL) begin
        ram_we = 1'b1;
        ram_wa = eprev_q[EW-1:0];
        ram_wd = prev_q;
        ram_wd.link = ram_rd.link;
      end
      default: ;
    endcase
    unique case (state_q)
      S_ENQ_LINK: ram_ra = tail_q[slot_q][EW-1:0];
      S_SND_TRY, S_SND_NX, S_SND_RD: ram_ra = send_q[cur_q][EW-1:0];
      default: ;
    endcase
  end

  // word of each entry passed over becomes the previous word
  always_ff @(posedge clk_i) begin
    if (state_q == S_ACK_CHK && !ack_hit) prev_q <= ram_rd;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(ENTRY_DEPTH))
    else $error("held count above depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("accepting while result pending");
endmodule
